// ===== sv/obc_pkg.sv =====
package obc_pkg;

   // Quotient bits retired per divider cycle
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_WIDTH      = 64;
   localparam int DSR_WIDTH      = 32;
   localparam int DIV_FULL_STEPS = DIV_WIDTH / DIV_RADIX_BITS;
   localparam int DIV_HALF_STEPS = DSR_WIDTH / DIV_RADIX_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_FULL_STEPS + 1);

   typedef struct packed {
      logic signed [31:0] x_sample;
      logic signed [31:0] y_sample;
      logic               start_req;
   } obc_req_type;

   typedef struct packed {
      logic signed [31:0] mean_x;
      logic signed [31:0] mean_y;
      logic [62:0]        var_x;
      logic [62:0]        var_y;
      logic signed [63:0] covariance;
      logic [31:0]        sample_count;
   } obc_rsp_type;

   // Command to the shared divider
   typedef struct packed {
      logic                    go;
      logic [DIV_WIDTH-1:0]    dividend;
      logic [DSR_WIDTH-1:0]    divisor;
      logic [DIV_CNT_BITS-1:0] steps;
   } obc_div_cmd_type;

   // Divider status and result
   typedef struct packed {
      logic                 done;
      logic [DIV_WIDTH-1:0] quot;
   } obc_div_rsp_type;

endpackage

// ===== sv/online_bivariate_covariance_unit.sv =====
// The shared divider serves five divisions per transaction: two of 32 quotient bits for
// the means and three of 64 for the covariance and the two variances, four bits per cycle.
// No new transaction is taken until the previous result is in the output register.
// A new transaction is accepted while the previous result still waits to be taken.
// Synchronous reset clears the running statistics to an empty set and empties the output.
module online_bivariate_covariance_unit #(
   parameter int COUNT_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  obc_pkg::obc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output obc_pkg::obc_rsp_type rsp_data
);
   import obc_pkg::*;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
   localparam logic [62:0]           VAR_MAX = {63{1'b1}};

   typedef enum logic [4:0] {
      ST_IDLE, ST_DQX, ST_WQX, ST_DQY, ST_WQY, ST_MYQ, ST_WCV, ST_PQ, ST_PLO,
      ST_PHI, ST_PSUM, ST_PNEG, ST_PADD, ST_WVX, ST_DVY, ST_WVY, ST_OUT
   } state_type;

   state_type               state_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic signed [31:0]      mean_x_ff;
   logic signed [31:0]      mean_y_ff;
   logic [63:0]             sqx_ff;
   logic [63:0]             sqy_ff;
   logic signed [63:0]      cov_ff;
   logic signed [31:0]      x_ff;
   logic signed [31:0]      y_ff;
   logic [31:0]             dxm_x_ff;
   logic [31:0]             dxm_y_ff;
   logic                    dxneg_x_ff;
   logic                    dxneg_y_ff;
   logic [31:0]             qm_x_ff;
   logic [31:0]             qm_y_ff;
   logic [31:0]             mhi_ff;
   logic [63:0]             plo_ff;
   logic [62:0]             tmag_ff;
   logic signed [63:0]      t_ff;
   logic [62:0]             vx_ff;
   obc_rsp_type             rsp_ff;
   logic                    rsp_valid_ff;

   obc_div_cmd_type         div_cmd;
   obc_div_rsp_type         div_rsp;
   logic                    mul_en;
   logic [31:0]             mul_a;
   logic [31:0]             mul_b;
   logic [63:0]             mul_p;

   logic signed [32:0]      dev_x;
   logic signed [32:0]      dev_y;
   logic [32:0]             dev_x_neg;
   logic [32:0]             dev_y_neg;
   logic [31:0]             absdev_x;
   logic [31:0]             absdev_y;
   logic [63:0]             abscov;
   logic [31:0]             nm1;
   logic [31:0]             divisor;
   logic [31:0]             q_lo;
   logic [95:0]             prod_sum;
   logic                    accept;
   logic                    rsp_free;

   function automatic logic [63:0] add_sat_u(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic signed [63:0] add_sat_s(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic [62:0] sat63(input logic [63:0] v);
      return v[63] ? VAR_MAX : v[62:0];
   endfunction

   // Deviation of each sample from its current mean, and magnitudes
   assign dev_x     = {x_ff[31], x_ff} - {mean_x_ff[31], mean_x_ff};
   assign dev_y     = {y_ff[31], y_ff} - {mean_y_ff[31], mean_y_ff};
   assign dev_x_neg = -dev_x;
   assign dev_y_neg = -dev_y;
   assign absdev_x  = dev_x[32] ? dev_x_neg[31:0] : dev_x[31:0];
   assign absdev_y  = dev_y[32] ? dev_y_neg[31:0] : dev_y[31:0];
   assign abscov    = cov_ff[63] ? 64'(-cov_ff) : 64'(cov_ff);
   assign divisor   = 32'(count_ff);
   assign nm1       = 32'(count_ff - CNT_ONE);
   assign q_lo      = div_rsp.quot[31:0];
   assign prod_sum  = {32'b0, plo_ff} + {mul_p, 32'b0};

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Divider commands
   always_comb begin
      div_cmd.go       = 1'b0;
      div_cmd.dividend = '0;
      div_cmd.divisor  = divisor;
      div_cmd.steps    = DIV_CNT_BITS'(DIV_FULL_STEPS);
      unique case (state_ff)
         ST_DQX: begin
            div_cmd.go       = 1'b1;
            div_cmd.dividend = {absdev_x, 32'b0};
            div_cmd.steps    = DIV_CNT_BITS'(DIV_HALF_STEPS);
         end
         ST_DQY: begin
            div_cmd.go       = 1'b1;
            div_cmd.dividend = {absdev_y, 32'b0};
            div_cmd.steps    = DIV_CNT_BITS'(DIV_HALF_STEPS);
         end
         ST_MYQ: begin
            div_cmd.go       = 1'b1;
            div_cmd.dividend = abscov;
         end
         ST_PQ: begin
            div_cmd.go       = 1'b1;
            div_cmd.dividend = sqx_ff;
         end
         ST_DVY: begin
            div_cmd.go       = 1'b1;
            div_cmd.dividend = sqy_ff;
         end
         default: begin
         end
      endcase
   end

   // Multiplier operands
   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         ST_DQY: begin
            mul_en = 1'b1;
            mul_a  = dxm_x_ff;
            mul_b  = absdev_x;
         end
         ST_MYQ: begin
            mul_en = 1'b1;
            mul_a  = dxm_y_ff;
            mul_b  = absdev_y;
         end
         ST_PQ: begin
            mul_en = 1'b1;
            mul_a  = qm_x_ff;
            mul_b  = qm_y_ff;
         end
         ST_PLO: begin
            mul_en = 1'b1;
            mul_a  = mul_p[31:0];
            mul_b  = nm1;
         end
         ST_PHI: begin
            mul_en = 1'b1;
            mul_a  = mhi_ff;
            mul_b  = nm1;
         end
         default: begin
         end
      endcase
   end

   obc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_rsp (div_rsp)
   );

   obc_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   // Sequencer, running state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mean_x_ff    <= '0;
         mean_y_ff    <= '0;
         sqx_ff       <= '0;
         sqy_ff       <= '0;
         cov_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Output valid: raised when the result is loaded, dropped once taken
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  x_ff <= req_data.x_sample;
                  y_ff <= req_data.y_sample;
                  if (req_data.start_req) begin
                     count_ff  <= CNT_ONE;
                     mean_x_ff <= '0;
                     mean_y_ff <= '0;
                     sqx_ff    <= '0;
                     sqy_ff    <= '0;
                     cov_ff    <= '0;
                  end else if (count_ff != CNT_MAX) begin
                     count_ff <= count_ff + CNT_ONE;
                  end
                  state_ff <= ST_DQX;
               end
            end
            ST_DQX: begin
               dxm_x_ff   <= absdev_x;
               dxneg_x_ff <= dev_x[32];
               state_ff   <= ST_WQX;
            end
            ST_WQX: begin
               if (div_rsp.done) begin
                  qm_x_ff   <= q_lo;
                  mean_x_ff <= dxneg_x_ff ? mean_x_ff - q_lo : mean_x_ff + q_lo;
                  state_ff  <= ST_DQY;
               end
            end
            ST_DQY: begin
               dxm_y_ff   <= absdev_y;
               dxneg_y_ff <= dev_y[32];
               state_ff   <= ST_WQY;
            end
            ST_WQY: begin
               if (div_rsp.done) begin
                  qm_y_ff   <= q_lo;
                  mean_y_ff <= dxneg_y_ff ? mean_y_ff - q_lo : mean_y_ff + q_lo;
                  sqx_ff    <= add_sat_u(sqx_ff, mul_p);
                  state_ff  <= ST_MYQ;
               end
            end
            ST_MYQ: begin
               state_ff <= ST_WCV;
            end
            ST_WCV: begin
               if (div_rsp.done) begin
                  sqy_ff   <= add_sat_u(sqy_ff, mul_p);
                  // run_cov minus run_cov / n, truncated toward zero
                  cov_ff   <= cov_ff[63] ? cov_ff + $signed(div_rsp.quot)
                                         : cov_ff - $signed(div_rsp.quot);
                  state_ff <= ST_PQ;
               end
            end
            ST_PQ: begin
               state_ff <= ST_PLO;
            end
            ST_PLO: begin
               mhi_ff   <= mul_p[63:32];
               state_ff <= ST_PHI;
            end
            ST_PHI: begin
               plo_ff   <= mul_p;
               state_ff <= ST_PSUM;
            end
            ST_PSUM: begin
               // (n - 1) * |qx| * |qy|, clamped to the signed maximum
               tmag_ff  <= (prod_sum[95:63] != '0) ? VAR_MAX : prod_sum[62:0];
               state_ff <= ST_PNEG;
            end
            ST_PNEG: begin
               t_ff     <= (dxneg_x_ff ^ dxneg_y_ff) ? -$signed({1'b0, tmag_ff})
                                                     : $signed({1'b0, tmag_ff});
               state_ff <= ST_PADD;
            end
            ST_PADD: begin
               cov_ff   <= add_sat_s(cov_ff, t_ff);
               state_ff <= ST_WVX;
            end
            ST_WVX: begin
               if (div_rsp.done) begin
                  vx_ff    <= sat63(div_rsp.quot);
                  state_ff <= ST_DVY;
               end
            end
            ST_DVY: begin
               state_ff <= ST_WVY;
            end
            ST_WVY: begin
               if (div_rsp.done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_free) begin
                  rsp_ff.mean_x       <= mean_x_ff;
                  rsp_ff.mean_y       <= mean_y_ff;
                  rsp_ff.var_x        <= vx_ff;
                  rsp_ff.var_y        <= sat63(div_rsp.quot);
                  rsp_ff.covariance   <= cov_ff;
                  rsp_ff.sample_count <= 32'(count_ff);
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/obc_div.sv =====
module obc_div (
   input  logic                     clock,
   input  logic                     reset,
   input  obc_pkg::obc_div_cmd_type div_cmd,
   output obc_pkg::obc_div_rsp_type div_rsp
);
   import obc_pkg::*;

   logic [DIV_WIDTH-1:0]    quo_ff;
   logic [DIV_WIDTH-1:0]    quo_in;
   logic [DSR_WIDTH-1:0]    rem_ff;
   logic [DSR_WIDTH-1:0]    rem_in;
   logic [DSR_WIDTH-1:0]    dsr_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    done_ff;

   // Restoring division, several quotient bits per cycle
   always_comb begin
      logic [DSR_WIDTH:0] trial;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         trial  = {rem_in, quo_in[DIV_WIDTH-1]};
         quo_in = {quo_in[DIV_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in    = DSR_WIDTH'(trial - {1'b0, dsr_ff});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[DSR_WIDTH-1:0];
         end
      end
   end

   // Iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (div_cmd.go) begin
         cnt_ff  <= div_cmd.steps;
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            done_ff <= 1'b1;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (div_cmd.go) begin
         quo_ff <= div_cmd.dividend;
         rem_ff <= '0;
         dsr_ff <= div_cmd.divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

// ===== sv/obc_mul.sv =====
module obc_mul (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod
);

   logic [63:0] prod_ff;

   // Registered 32x32 unsigned product, held until the next issue
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= 64'(op_a) * 64'(op_b);
      end
   end

   assign prod = prod_ff;

endmodule
